>>> hdl/ccml_pkg.sv
// Shared constants and types for the composition count lookup block.
`default_nettype none
package ccml_pkg;

    localparam int MAX_ROW = 255;
    localparam int ROW_W   = $clog2(MAX_ROW + 1);
    localparam int ADDR_W  = 2 * ROW_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int CNT_W   = 20;
    localparam int MOD_W   = 21;
    localparam int TOT_W   = 8;
    localparam int PART_W  = 9;
    localparam int QROW_W  = 10;

    localparam logic [MOD_W-1:0] RESET_MODULUS = MOD_W'(1000000);
    localparam logic [MOD_W-1:0] MODULUS_CAP   = MOD_W'(1048576);

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_PARTS  = 2'd1,
        STS_OUT_RANGE = 2'd2
    } t_status;

endpackage
`default_nettype wire

>>> hdl/composition_count_mod_lookup.sv
// Pascal triangle mod m in one RAM, rebuilt on reset and modulus writes, read by queries.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  query in | input     | i_valid / o_stall       | i_total, i_parts
//  result   | output    | o_valid / i_stall       | o_count, o_status
//  config   | input     | i_cfg_valid/o_cfg_ready | i_cfg_modulus
//
// After reset and after each modulus write the triangle is built into the RAM,
// one entry per cycle, with o_stall high.
// Queries then take one item per cycle while o_stall is low; each result passes
// through the RAM read register and then the output register before o_valid.
// Synchronous active-low reset restarts the build with modulus 1000000.
// A stalled result holds; one more item is taken into the read stage behind it.
`default_nettype none
module composition_count_mod_lookup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [ccml_pkg::TOT_W-1:0]    i_total,
    input  wire logic [ccml_pkg::PART_W-1:0]   i_parts,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [ccml_pkg::CNT_W-1:0]    o_count,
    output      logic [1:0]                    o_status,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [ccml_pkg::MOD_W-1:0]    i_cfg_modulus
);

    typedef enum logic {ST_BUILD, ST_RUN} t_state;

    localparam int RW = ccml_pkg::ROW_W;
    localparam int AW = ccml_pkg::ADDR_W;
    localparam int CW = ccml_pkg::CNT_W;
    localparam int MW = ccml_pkg::MOD_W;
    localparam int QW = ccml_pkg::QROW_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(ccml_pkg::MAX_ROW);

    logic [CW-1:0] r_mem [ccml_pkg::DEPTH];
    logic [CW-1:0] r_rdata;

    t_state          r_state;
    logic [MW-1:0]   r_m;
    logic [RW-1:0]   r_row, r_col;
    logic            r_issue;
    logic            r_bv, r_bfirst, r_blast;
    logic [RW-1:0]   r_brow, r_bcol;
    logic [CW-1:0]   r_prev;

    logic            r_s1_v;
    ccml_pkg::t_status r_s1_sts;
    logic            r_o_valid;
    logic [CW-1:0]   r_count;
    ccml_pkg::t_status r_sts;

    logic            cfg_wr, adv_out, accept, rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr, q_addr;
    logic [MW-1:0]   n_m;
    logic [CW-1:0]   one, cur, wr_data, red;
    logic [MW-1:0]   sum;
    logic [QW-1:0]   q_row, q_col;
    ccml_pkg::t_status q_sts;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        if (i_cfg_modulus == '0) begin
            n_m = MW'(1);
        end else if (i_cfg_modulus > ccml_pkg::MODULUS_CAP) begin
            n_m = ccml_pkg::MODULUS_CAP;
        end else begin
            n_m = i_cfg_modulus;
        end
    end

    // build datapath: prev holds C(i-1,j-1), RAM data gives C(i-1,j)
    assign one     = (r_m == MW'(1)) ? '0 : CW'(1);
    assign cur     = r_blast ? '0 : r_rdata;
    assign sum     = {1'b0, r_prev} + {1'b0, cur};
    assign red     = (sum >= r_m) ? CW'(sum - r_m) : CW'(sum);
    assign wr_data = r_bfirst ? one : red;
    assign wr_addr = {r_brow, r_bcol};
    assign wr_en   = r_bv && (r_state == ST_BUILD);

    // query decode
    assign q_row = QW'(i_total) + QW'(i_parts) - QW'(1);
    assign q_col = QW'(i_parts) - QW'(1);
    always_comb begin
        if (i_parts == '0) begin
            q_sts = ccml_pkg::STS_NO_PARTS;
        end else if (q_row > QW'(ccml_pkg::MAX_ROW)) begin
            q_sts = ccml_pkg::STS_OUT_RANGE;
        end else begin
            q_sts = ccml_pkg::STS_OK;
        end
    end
    assign q_addr = {q_row[RW-1:0], q_col[RW-1:0]};

    assign adv_out = !r_o_valid || !i_stall;
    assign accept  = (r_state == ST_RUN) && i_valid && (!r_s1_v || adv_out);
    assign o_stall = (r_state != ST_RUN) || (r_s1_v && !adv_out);

    always_comb begin
        if (r_state == ST_BUILD) begin
            rd_en   = r_issue;
            rd_addr = {r_row - RW'(1), r_col};
        end else begin
            rd_en   = accept;
            rd_addr = q_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_state <= ST_BUILD;
            r_m     <= i_rst_n ? n_m : ccml_pkg::RESET_MODULUS;
            r_row   <= '0;
            r_col   <= '0;
            r_issue <= 1'b1;
            r_bv    <= 1'b0;
        end else if (r_state == ST_BUILD) begin
            r_bv     <= r_issue;
            r_brow   <= r_row;
            r_bcol   <= r_col;
            r_bfirst <= (r_col == '0);
            r_blast  <= (r_col == r_row);
            if (r_issue) begin
                if (r_col == r_row) begin
                    r_col <= '0;
                    if (r_row == LAST_ROW) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + RW'(1);
                end
            end
            if (r_bv) begin
                r_prev <= r_bfirst ? one : cur;
                if (r_blast && r_brow == LAST_ROW) begin
                    r_state <= ST_RUN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v   <= 1'b1;
                r_s1_sts <= q_sts;
            end else if (adv_out) begin
                r_s1_v <= 1'b0;
            end
            if (adv_out) begin
                r_o_valid <= r_s1_v;
                if (r_s1_v) begin
                    r_sts   <= r_s1_sts;
                    r_count <= (r_s1_sts == ccml_pkg::STS_OK) ? r_rdata : '0;
                end
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_count  = r_count;
    assign o_status = r_sts;

endmodule
`default_nettype wire

>>> test/tb_composition_count_mod_lookup.sv
// Testbench for composition_count_mod_lookup: binomial table queries checked against a predictor.

typedef struct {
    logic [ccml_pkg::CNT_W-1:0] count;
    ccml_pkg::t_status          status;
} t_expected;

class composition_scoreboard;
    logic [ccml_pkg::CNT_W-1:0] binom [ccml_pkg::MAX_ROW+1][ccml_pkg::MAX_ROW+1];
    t_expected                  pending_counts[$];
    int                         mismatches;
    int                         noted;
    int                         checked;

    function new();
        mismatches = 0;
        noted      = 0;
        checked    = 0;
        load_modulus(ccml_pkg::RESET_MODULUS);
    endfunction

    // Rebuild the triangle the way the block does after a modulus write.
    function void load_modulus(logic [ccml_pkg::MOD_W-1:0] reg_value);
        int unsigned m;
        int unsigned one;
        int unsigned s;
        int          r;
        int          c;
        m = 32'(reg_value);
        if (m == 0) begin
            m = 1;
        end else if (m > ccml_pkg::MODULUS_CAP) begin
            m = ccml_pkg::MODULUS_CAP;
        end
        one = 1 % m;
        for (r = 0; r <= ccml_pkg::MAX_ROW; r++) begin
            for (c = 0; c <= ccml_pkg::MAX_ROW; c++) begin
                binom[r][c] = '0;
            end
        end
        binom[0][0] = ccml_pkg::CNT_W'(one);
        for (r = 1; r <= ccml_pkg::MAX_ROW; r++) begin
            binom[r][0] = ccml_pkg::CNT_W'(one);
            for (c = 1; c <= r; c++) begin
                s = int'(binom[r-1][c-1]) + int'(binom[r-1][c]);
                binom[r][c] = ccml_pkg::CNT_W'(s % m);
            end
        end
    endfunction

    function void note_query(logic [ccml_pkg::TOT_W-1:0] total,
                             logic [ccml_pkg::PART_W-1:0] parts);
        t_expected    e;
        int           row;
        noted++;
        e.count  = '0;
        e.status = ccml_pkg::STS_OK;
        if (parts == 0) begin
            e.status = ccml_pkg::STS_NO_PARTS;
        end else begin
            row = int'(total) + int'(parts) - 1;
            if (row > ccml_pkg::MAX_ROW) begin
                e.status = ccml_pkg::STS_OUT_RANGE;
            end else begin
                e.count = binom[row][parts-1];
            end
        end
        pending_counts = {pending_counts, e};
    endfunction

    function void report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endfunction

    function void check_result(logic [ccml_pkg::CNT_W-1:0] count, logic [1:0] status);
        t_expected e;
        checked++;
        if (pending_counts.size() == 0) begin
            report($sformatf("result %0d: count %0d status %0d with no item pending",
                             checked, count, status));
            return;
        end
        e = pending_counts.pop_front();
        if (status !== e.status) begin
            report($sformatf("result %0d: status %0d, expected %0d",
                             checked, status, e.status));
        end
        if (count !== e.count) begin
            report($sformatf("result %0d: count %0d, expected %0d",
                             checked, count, e.count));
        end
    endfunction
endclass

module tb_composition_count_mod_lookup;

    localparam int CYCLE_LIMIT    = 1500000;
    localparam int PHASES         = 8;
    localparam int RANDOM_PER_SET = 54;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic [ccml_pkg::TOT_W-1:0]    i_total       = '0;
    logic [ccml_pkg::PART_W-1:0]   i_parts       = '0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [ccml_pkg::CNT_W-1:0]    o_count;
    logic [1:0]                    o_status;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [ccml_pkg::MOD_W-1:0]    i_cfg_modulus = '0;

    composition_scoreboard         sb;
    int                            send_pct      = 0;
    int                            recv_pct      = 0;
    int                            cycle_count   = 0;
    logic [ccml_pkg::MOD_W-1:0]    mod_settings [PHASES];

    composition_count_mod_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_total       (i_total),
        .i_parts       (i_parts),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_count       (o_count),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_count, o_status);
        end
        i_stall <= ($urandom_range(99) < recv_pct);
    end

    task automatic send_query(input logic [ccml_pkg::TOT_W-1:0] total,
                              input logic [ccml_pkg::PART_W-1:0] parts);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_total <= total;
        i_parts <= parts;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_query(total, parts);
    endtask

    // Mostly in-table queries; some zero-part and unconstrained ones.
    task automatic send_random_query();
        int sel;
        int parts;
        int total;
        sel = $urandom_range(99);
        if (sel < 70) begin
            parts = $urandom_range(ccml_pkg::MAX_ROW + 1, 1);
            total = $urandom_range(ccml_pkg::MAX_ROW + 1 - parts, 0);
        end else if (sel < 80) begin
            parts = 0;
            total = $urandom_range(255, 0);
        end else begin
            parts = $urandom_range(511, 0);
            total = $urandom_range(255, 0);
        end
        send_query(total[7:0], parts[8:0]);
    endtask

    task automatic drain();
        while (sb.pending_counts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [ccml_pkg::MOD_W-1:0] value);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.load_modulus(value);
    endtask

    task automatic send_directed();
        send_query(8'd0,   9'd0);
        send_query(8'd255, 9'd0);
        send_query(8'd0,   9'd1);
        send_query(8'd255, 9'd1);
        send_query(8'd0,   9'd256);
        send_query(8'd1,   9'd255);
        send_query(8'd128, 9'd128);
        send_query(8'd127, 9'd129);
        send_query(8'd1,   9'd256);
        send_query(8'd255, 9'd2);
        send_query(8'd0,   9'd257);
        send_query(8'd0,   9'd511);
        send_query(8'd255, 9'd511);
        send_query(8'd100, 9'd50);
        send_query(8'd1,   9'd1);
        send_query(8'd2,   9'd2);
        send_query(8'd170, 9'd85);
        send_query(8'd30,  9'd2);
    endtask

    initial begin
        int p;
        sb = new();
        mod_settings[0] = ccml_pkg::RESET_MODULUS;
        mod_settings[1] = '0;
        mod_settings[2] = 21'd1;
        mod_settings[3] = ccml_pkg::MODULUS_CAP;
        mod_settings[4] = '1;
        mod_settings[5] = 21'd2;
        mod_settings[6] = ccml_pkg::MOD_W'($urandom_range(1048575, 3));
        mod_settings[7] = mod_settings[6];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_pct = 15;
                recv_pct = 68;
            end else if (p < 6) begin
                send_pct = 68;
                recv_pct = 15;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            if (p == 0) begin
                send_directed();
            end else begin
                drain();
                write_modulus(mod_settings[p]);
            end
            repeat (RANDOM_PER_SET) send_random_query();
            i_valid <= 1'b0;
        end
        while (sb.pending_counts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d queries sent, %0d results checked across %0d modulus settings",
                 sb.noted, sb.checked, PHASES);
        $display("settings included zero, one, the cap, all ones and a repeated write");
        if (sb.pending_counts.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending_counts.size()));
        end
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ccml_pkg.sv
hdl/composition_count_mod_lookup.sv
test/tb_composition_count_mod_lookup.sv
